>>> src/assert_macros.svh
// shared assertion macros for the deframer checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

>>> src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the frame deframer: result kinds, frame
// status codes, header layout and the result record.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int FieldLenW   = 24;
  localparam int HeaderBytes = 8;
  localparam int SyncLength  = 4;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_SYNC    = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SUM    = 2'd1;
  localparam logic [1:0] STATUS_LENGTH = 2'd2;

  localparam logic [2:0] HDR_LEN0   = 3'd0;
  localparam logic [2:0] HDR_LEN1   = 3'd1;
  localparam logic [2:0] HDR_LEN2   = 3'd2;
  localparam logic [2:0] HDR_SUM    = 3'd3;
  localparam logic [2:0] HDR_ID_LO  = 3'd4;
  localparam logic [2:0] HDR_ID_HI  = 3'd5;
  localparam logic [2:0] HDR_CODE_LO = 3'd6;
  localparam logic [2:0] HDR_CODE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           data;
    logic                 last;
    logic [1:0]           status;
    logic [15:0]          id;
    logic [15:0]          code;
    logic [FieldLenW-1:0] length;
  } result_t;

endpackage

>>> src/sync_aware_frame_deframer.sv
// ----------------------------------------------------------------------------
// sync_aware_frame_deframer
// Byte-serial deframer for a length-prefixed link protocol with sync groups.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// rx       in         rx_valid / rx_ready       rx_byte
// out      out        out_valid / out_ready     result_kind .. frame_length
// apb      in         psel, penable, pready     paddr, pwdata, prdata
//
// one byte per cycle while rx_ready is high; a byte's result is registered
// the header/payload update is a single pass of compare, add and count logic
// an output register plus a skid register let rx take a byte while a result
// waits; rx_ready drops only while the skid register is full
// rst is synchronous and clears the parser, the seed and both valid flags
// ----------------------------------------------------------------------------
module sync_aware_frame_deframer #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // receive bytes
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  payload_byte,
  output logic        frame_last,
  output logic [1:0]  frame_status,
  output logic [15:0] message_id,
  output logic [15:0] msg_code,
  output logic [23:0] frame_length
);

  localparam int LenW = (LENGTH_BITS < sfd_pkg::FieldLenW) ? LENGTH_BITS
                                                            : sfd_pkg::FieldLenW;

  // configuration register
  logic [7:0] checksum_seed;

  // parser state
  logic            in_payload, in_payload_next;
  logic [2:0]      header_index, header_index_next;
  logic [LenW-1:0] length_reg, length_reg_next;
  logic [7:0]      expected_sum, expected_sum_next;
  logic [7:0]      running_sum, running_sum_next;
  logic [15:0]     id_reg, id_reg_next;
  logic [15:0]     code_reg, code_reg_next;
  logic [LenW-1:0] bytes_left, bytes_left_next;
  logic            sync_run, sync_run_next;

  logic                       rx_fire;
  logic                       res_fire;
  sfd_pkg::result_t           res;
  logic [sfd_pkg::FieldLenW-1:0] len_ext;
  logic [sfd_pkg::FieldLenW-1:0] len_asm;
  logic [7:0]                 sum_add;

  sfd_pkg::result_t out_q, skid_q;
  logic             skid_valid;
  logic             out_fire;

  // apb port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, checksum_seed} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_seed <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      checksum_seed <= pwdata[7:0];
    end
  end

  assign rx_ready = !skid_valid;
  assign rx_fire  = rx_valid && rx_ready;
  assign out_fire = out_valid && out_ready;
  assign sum_add  = running_sum + rx_byte;

  always_comb begin
    len_ext = '0;
    len_ext[LenW-1:0] = length_reg;
  end

  always_comb begin
    in_payload_next   = in_payload;
    header_index_next = header_index;
    length_reg_next   = length_reg;
    expected_sum_next = expected_sum;
    running_sum_next  = running_sum;
    id_reg_next       = id_reg;
    code_reg_next     = code_reg;
    bytes_left_next   = bytes_left;
    sync_run_next     = sync_run;
    res_fire          = 1'b0;
    res.kind          = sfd_pkg::KIND_PAYLOAD;
    res.data          = 8'd0;
    res.last          = 1'b0;
    res.status        = sfd_pkg::STATUS_OK;
    len_asm           = len_ext;

    if (in_payload) begin
      running_sum_next = sum_add;
      res_fire         = 1'b1;
      res.data         = rx_byte;
      if (bytes_left != '0) begin
        bytes_left_next = bytes_left - LenW'(1);
      end
      if (bytes_left_next == '0) begin
        in_payload_next   = 1'b0;
        header_index_next = sfd_pkg::HDR_LEN0;
        res.last          = 1'b1;
        res.status        = (sum_add == expected_sum) ? sfd_pkg::STATUS_OK
                                                      : sfd_pkg::STATUS_SUM;
      end
    end else begin
      header_index_next = header_index + 3'd1;
      case (header_index)
        sfd_pkg::HDR_LEN0: begin
          running_sum_next = checksum_seed;
          len_asm          = {16'd0, rx_byte};
          length_reg_next  = len_asm[LenW-1:0];
        end
        sfd_pkg::HDR_LEN1: begin
          len_asm         = len_ext | {8'd0, rx_byte, 8'd0};
          length_reg_next = len_asm[LenW-1:0];
        end
        sfd_pkg::HDR_LEN2: begin
          len_asm         = len_ext | {rx_byte, 16'd0};
          length_reg_next = len_asm[LenW-1:0];
        end
        sfd_pkg::HDR_SUM: begin
          expected_sum_next = rx_byte;
          if (length_reg == LenW'(sfd_pkg::SyncLength) && rx_byte == checksum_seed) begin
            header_index_next = sfd_pkg::HDR_LEN0;
            // only the first group of a run is reported
            if (!sync_run) begin
              sync_run_next = 1'b1;
              res_fire      = 1'b1;
              res.kind      = sfd_pkg::KIND_SYNC;
            end
          end else begin
            sync_run_next = 1'b0;
          end
        end
        sfd_pkg::HDR_ID_LO: begin
          id_reg_next      = {8'd0, rx_byte};
          running_sum_next = sum_add;
        end
        sfd_pkg::HDR_ID_HI: begin
          id_reg_next      = {rx_byte, id_reg[7:0]};
          running_sum_next = sum_add;
        end
        sfd_pkg::HDR_CODE_LO: begin
          code_reg_next    = {8'd0, rx_byte};
          running_sum_next = sum_add;
        end
        sfd_pkg::HDR_CODE_HI: begin
          code_reg_next     = {rx_byte, code_reg[7:0]};
          running_sum_next  = sum_add;
          header_index_next = sfd_pkg::HDR_LEN0;
          if (length_reg < LenW'(sfd_pkg::HeaderBytes)) begin
            res_fire   = 1'b1;
            res.kind   = sfd_pkg::KIND_END;
            res.last   = 1'b1;
            res.status = sfd_pkg::STATUS_LENGTH;
          end else if (length_reg == LenW'(sfd_pkg::HeaderBytes)) begin
            res_fire   = 1'b1;
            res.kind   = sfd_pkg::KIND_END;
            res.last   = 1'b1;
            res.status = (sum_add == expected_sum) ? sfd_pkg::STATUS_OK
                                                   : sfd_pkg::STATUS_SUM;
          end else begin
            bytes_left_next = length_reg - LenW'(sfd_pkg::HeaderBytes);
            in_payload_next = 1'b1;
          end
        end
        default: begin
          header_index_next = sfd_pkg::HDR_LEN0;
        end
      endcase
    end

    // header fields as they stand after this byte
    res.id     = id_reg_next;
    res.code   = code_reg_next;
    res.length = '0;
    res.length[LenW-1:0] = length_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      header_index <= sfd_pkg::HDR_LEN0;
      length_reg   <= '0;
      expected_sum <= '0;
      running_sum  <= '0;
      id_reg       <= '0;
      code_reg     <= '0;
      bytes_left   <= '0;
      sync_run     <= 1'b0;
    end else if (rx_fire) begin
      in_payload   <= in_payload_next;
      header_index <= header_index_next;
      length_reg   <= length_reg_next;
      expected_sum <= expected_sum_next;
      running_sum  <= running_sum_next;
      id_reg       <= id_reg_next;
      code_reg     <= code_reg_next;
      bytes_left   <= bytes_left_next;
      sync_run     <= sync_run_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (rx_fire && res_fire) begin
      if (!out_valid || out_fire) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign result_kind  = out_q.kind;
  assign payload_byte = out_q.data;
  assign frame_last   = out_q.last;
  assign frame_status = out_q.status;
  assign message_id   = out_q.id;
  assign msg_code     = out_q.code;
  assign frame_length = out_q.length;

endmodule

>>> src/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [7:0]  payload_byte,
  input logic        frame_last,
  input logic [1:0]  frame_status,
  input logic [15:0] message_id,
  input logic [15:0] msg_code,
  input logic [23:0] frame_length
);

  logic        stalled;
  logic [68:0] out_bundle;

  assign stalled    = out_valid && !out_ready;
  assign out_bundle = {result_kind, payload_byte, frame_last, frame_status,
                       message_id, msg_code, frame_length};

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, stalled, out_valid && $stable(out_bundle))

  // only payload items carry a data byte
  `ASSERT_IMPL(a_byte_zero, clk, rst,
               out_valid && result_kind != sfd_pkg::KIND_PAYLOAD, payload_byte == 8'd0)

  // status stays ok unless the item closes a frame
  `ASSERT_IMPL(a_status_last, clk, rst,
               out_valid && !frame_last, frame_status == sfd_pkg::STATUS_OK)

  // sync items never close a frame, frame-end items always do
  `ASSERT_IMPL(a_kind_last, clk, rst,
               out_valid && (result_kind == sfd_pkg::KIND_SYNC ||
                             result_kind == sfd_pkg::KIND_END),
               frame_last == (result_kind == sfd_pkg::KIND_END))

endmodule

bind sync_aware_frame_deframer sfd_checker u_sfd_checker (.*);
